[hw/rtl/box_blur_3x3_truncated_top_assert.svh]
// assertion macros used by the blur back end
// both expect clk_i and rst_ni in scope
`ifndef BOX_BLUR_3X3_TRUNCATED_TOP_ASSERT_SVH
`define BOX_BLUR_3X3_TRUNCATED_TOP_ASSERT_SVH

// same-cycle implication
`define BB3_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// next-cycle implication
`define BB3_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

[hw/rtl/bb3_pkg.sv]
package bb3_pkg;

  localparam int unsigned MaxFrame       = 1024;
  localparam int unsigned ColW           = (MaxFrame > 1) ? $clog2(MaxFrame) : 1;
  localparam int unsigned CfgW           = 11;
  localparam int unsigned FrameSizeReset = 1024;
  localparam int unsigned ChanW          = 16;
  localparam int unsigned NumChan        = 3;
  localparam int unsigned RowSumW        = ChanW + 2;
  localparam int unsigned SumW           = ChanW + 4;
  localparam int unsigned CntW           = 4;
  localparam int unsigned MaxCount       = 9;
  localparam int unsigned RecipShift     = 24;
  localparam int unsigned RecipW         = RecipShift + 1;
  localparam int unsigned ProdW          = SumW + RecipW;
  localparam int unsigned PixW           = NumChan * ChanW;

  typedef logic [NumChan-1:0][ChanW-1:0] pix_t;

  typedef struct packed {
    logic [ChanW-1:0] in_red;
    logic [ChanW-1:0] in_green;
    logic [ChanW-1:0] in_blue;
  } pixel_in_t;

  typedef struct packed {
    logic [ChanW-1:0] out_red;
    logic [ChanW-1:0] out_green;
    logic [ChanW-1:0] out_blue;
    logic             frame_done;
  } pixel_out_t;

  typedef struct packed {
    logic            restart;
    logic [ColW-1:0] load_m1;
    logic [ColW-1:0] size_m1;
  } frame_ctl_t;

  typedef struct packed {
    pix_t            pix;
    logic [ColW-1:0] col;
    logic            right1;
    logic            right2;
    logic            below1;
    logic            below2;
    logic            done;
    logic [CntW-1:0] count;
  } cmd_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_ROWS,
    BK_SUM,
    BK_MUL,
    BK_PUSH
  } back_state_e;

  // frame size register value to last valid position
  function automatic logic [ColW-1:0] size_m1(input logic [CfgW-1:0] v);
    logic [ColW-1:0] res;
    if (v == '0) begin
      res = '0;
    end else if (int'(v) > int'(MaxFrame)) begin
      res = ColW'(MaxFrame - 1);
    end else begin
      res = ColW'(int'(v) - 1);
    end
    return res;
  endfunction

  // ceil(2^24 / d), exact truncating quotient for sums below 2^20
  function automatic logic [RecipW-1:0] recip(input logic [CntW-1:0] d);
    logic [RecipW-1:0] res;
    unique case (d)
      4'd2:    res = RecipW'(8388608);
      4'd3:    res = RecipW'(5592406);
      4'd4:    res = RecipW'(4194304);
      4'd5:    res = RecipW'(3355444);
      4'd6:    res = RecipW'(2796203);
      4'd7:    res = RecipW'(2396746);
      4'd8:    res = RecipW'(2097152);
      4'd9:    res = RecipW'(1864136);
      default: res = RecipW'(16777216);
    endcase
    return res;
  endfunction

endpackage

[hw/rtl/box_blur_3x3_truncated_top.sv]
// channel    ports                     transaction
// pixel in   push, full, in_i          push && !full
// result     empty, pop, out_o         pop && !empty
// config     cfg_we_i, cfg_wdata_i     cfg_we_i, frame size, restarts the frame
//
// the single-pixel back end takes the next pixel only when idle or in its push step,
// and steps through row sums, total, reciprocal multiply, result push
// front and back end each have a 2-entry queue, so input and output stall apart
// a stalled result holds the back end in its push step until a slot frees up
// reset sets both positions to frame size minus one and clears neighbors and queues
// line stores are not reset, an entry not yet written in a frame is read only for cells that are dropped
module box_blur_3x3_truncated_top import bb3_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [CfgW-1:0] cfg_wdata_i,
  input  logic            push,
  input  pixel_in_t       in_i,
  output logic            full,
  output logic            empty,
  output pixel_out_t      out_o,
  input  logic            pop
);

  logic [ColW-1:0] size_m1_q;
  frame_ctl_t      ctl;
  logic            cmd_valid, cmd_pop;
  cmd_t            cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_m1_q <= size_m1(CfgW'(FrameSizeReset));
    end else if (cfg_we_i) begin
      size_m1_q <= size_m1(cfg_wdata_i);
    end
  end

  always_comb begin
    ctl.restart = cfg_we_i;
    ctl.load_m1 = size_m1(cfg_wdata_i);
    ctl.size_m1 = size_m1_q;
  end

  bb3_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (ctl),
    .push        (push),
    .in_i        (in_i),
    .full        (full),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_pop_i   (cmd_pop)
  );

  bb3_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .restart_i   (cfg_we_i),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .empty       (empty),
    .out_o       (out_o),
    .pop         (pop)
  );

endmodule

[hw/rtl/bb3_ram.sv]
module bb3_ram #(
  parameter int unsigned Width = 48,
  parameter int unsigned Depth = 1024,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hw/rtl/bb3_front.sv]
module bb3_front import bb3_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  frame_ctl_t ctl_i,
  input  logic       push,
  input  pixel_in_t  in_i,
  output logic       full,
  output logic       cmd_valid_o,
  output cmd_t       cmd_o,
  input  logic       cmd_pop_i
);

  logic [ColW-1:0] row_q, col_q;
  logic [ColW-1:0] row_d, col_d;
  cmd_t            cmd_d;
  logic [CntW-1:0] cols, rows;
  logic            accept;

  cmd_t       fifo_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q;

  assign full   = (cnt_q == 2'd2);
  assign accept = push && !full;

  always_comb begin
    cmd_d.pix    = {in_i.in_blue, in_i.in_green, in_i.in_red};
    cmd_d.col    = col_q;
    cmd_d.right1 = (col_q != ctl_i.size_m1);
    cmd_d.right2 = ((ColW+1)'(col_q) + (ColW+1)'(1)) < (ColW+1)'(ctl_i.size_m1);
    cmd_d.below1 = (row_q != ctl_i.size_m1);
    cmd_d.below2 = ((ColW+1)'(row_q) + (ColW+1)'(1)) < (ColW+1)'(ctl_i.size_m1);
    cmd_d.done   = (row_q == '0) && (col_q == '0);
    cols         = CntW'(1) + CntW'(cmd_d.right1) + CntW'(cmd_d.right2);
    rows         = CntW'(1) + CntW'(cmd_d.below1) + CntW'(cmd_d.below2);
    cmd_d.count  = CntW'(cols * rows);

    row_d = row_q;
    col_d = col_q;
    if (col_q == '0) begin
      col_d = ctl_i.size_m1;
      row_d = (row_q == '0) ? ctl_i.size_m1 : row_q - ColW'(1);
    end else begin
      col_d = col_q - ColW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= ColW'(MaxFrame - 1);
      col_q <= ColW'(MaxFrame - 1);
    end else if (ctl_i.restart) begin
      row_q <= ctl_i.load_m1;
      col_q <= ctl_i.load_m1;
    end else if (accept) begin
      row_q <= row_d;
      col_q <= col_d;
    end
  end

  // command queue toward the back end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (accept) begin
        wptr_q <= ~wptr_q;
      end
      if (cmd_pop_i) begin
        rptr_q <= ~rptr_q;
      end
      cnt_q <= cnt_q + 2'(accept) - 2'(cmd_pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      fifo_q[wptr_q] <= cmd_d;
    end
  end

  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = fifo_q[rptr_q];

endmodule

[hw/rtl/bb3_back.sv]
`include "box_blur_3x3_truncated_top_assert.svh"

module bb3_back import bb3_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       restart_i,
  input  logic       cmd_valid_i,
  input  cmd_t       cmd_i,
  output logic       cmd_pop_o,
  output logic       empty,
  output pixel_out_t out_o,
  input  logic       pop
);

  back_state_e state_q, state_d;
  logic        cmd_pop, mem_we, res_push, res_pop;

  cmd_t cmd_q;
  pix_t below_rd, two_rd;
  pix_t rn1_q, rn2_q, b1_q, b2_q, t1_q, t2_q;

  logic [NumChan-1:0][RowSumW-1:0] row0_d, row1_d, row2_d;
  logic [NumChan-1:0][RowSumW-1:0] row0_q, row1_q, row2_q;
  logic [NumChan-1:0][SumW-1:0]    sum_q;
  logic [NumChan-1:0][ProdW-1:0]   prod_q;
  logic [RecipW-1:0]               rcp;

  pixel_out_t res_d;
  pixel_out_t res_fifo_q [2];
  logic       res_wptr_q, res_rptr_q;
  logic [1:0] res_cnt_q;

  bb3_ram #(.Width(PixW), .Depth(MaxFrame)) u_below_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (cmd_q.col),
    .wdata_i (cmd_q.pix),
    .re_i    (cmd_pop),
    .raddr_i (cmd_i.col),
    .rdata_o (below_rd)
  );

  bb3_ram #(.Width(PixW), .Depth(MaxFrame)) u_two_below_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (cmd_q.col),
    .wdata_i (below_rd),
    .re_i    (cmd_pop),
    .raddr_i (cmd_i.col),
    .rdata_o (two_rd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d  = state_q;
    cmd_pop  = 1'b0;
    mem_we   = 1'b0;
    res_push = 1'b0;
    unique case (state_q)
      BK_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop = 1'b1;
          state_d = BK_ROWS;
        end
      end
      BK_ROWS: begin
        mem_we  = 1'b1;
        state_d = BK_SUM;
      end
      BK_SUM: begin
        state_d = BK_MUL;
      end
      BK_MUL: begin
        state_d = BK_PUSH;
      end
      BK_PUSH: begin
        if (res_cnt_q != 2'd2) begin
          res_push = 1'b1;
          if (cmd_valid_i) begin
            cmd_pop = 1'b1;
            state_d = BK_ROWS;
          end else begin
            state_d = BK_IDLE;
          end
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  assign cmd_pop_o = cmd_pop;

  // per-row window sums, cells outside the frame dropped
  always_comb begin
    for (int k = 0; k < NumChan; k++) begin
      row0_d[k] = RowSumW'(cmd_q.pix[k])
                + (cmd_q.right1 ? RowSumW'(rn1_q[k]) : '0)
                + (cmd_q.right2 ? RowSumW'(rn2_q[k]) : '0);
      row1_d[k] = cmd_q.below1 ? (RowSumW'(below_rd[k])
                + (cmd_q.right1 ? RowSumW'(b1_q[k]) : '0)
                + (cmd_q.right2 ? RowSumW'(b2_q[k]) : '0)) : '0;
      row2_d[k] = cmd_q.below2 ? (RowSumW'(two_rd[k])
                + (cmd_q.right1 ? RowSumW'(t1_q[k]) : '0)
                + (cmd_q.right2 ? RowSumW'(t2_q[k]) : '0)) : '0;
    end
  end

  assign rcp = recip(cmd_q.count);

  always_ff @(posedge clk_i) begin
    if (cmd_pop) begin
      cmd_q <= cmd_i;
    end
    if (state_q == BK_ROWS) begin
      row0_q <= row0_d;
      row1_q <= row1_d;
      row2_q <= row2_d;
    end
    if (state_q == BK_SUM) begin
      for (int k = 0; k < NumChan; k++) begin
        sum_q[k] <= SumW'(row0_q[k]) + SumW'(row1_q[k]) + SumW'(row2_q[k]);
      end
    end
    if (state_q == BK_MUL) begin
      for (int k = 0; k < NumChan; k++) begin
        prod_q[k] <= ProdW'(sum_q[k]) * ProdW'(rcp);
      end
    end
  end

  // column neighbors of the current and the two lower rows
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rn1_q <= '0;
      rn2_q <= '0;
      b1_q  <= '0;
      b2_q  <= '0;
      t1_q  <= '0;
      t2_q  <= '0;
    end else if (restart_i) begin
      rn1_q <= '0;
      rn2_q <= '0;
      b1_q  <= '0;
      b2_q  <= '0;
      t1_q  <= '0;
      t2_q  <= '0;
    end else if (mem_we) begin
      rn2_q <= rn1_q;
      rn1_q <= cmd_q.pix;
      b2_q  <= b1_q;
      b1_q  <= below_rd;
      t2_q  <= t1_q;
      t1_q  <= two_rd;
    end
  end

  always_comb begin
    res_d.out_red    = prod_q[0][RecipShift+ChanW-1:RecipShift];
    res_d.out_green  = prod_q[1][RecipShift+ChanW-1:RecipShift];
    res_d.out_blue   = prod_q[2][RecipShift+ChanW-1:RecipShift];
    res_d.frame_done = cmd_q.done;
  end

  // result queue
  assign res_pop = pop && !empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_wptr_q <= 1'b0;
      res_rptr_q <= 1'b0;
      res_cnt_q  <= 2'd0;
    end else begin
      if (res_push) begin
        res_wptr_q <= ~res_wptr_q;
      end
      if (res_pop) begin
        res_rptr_q <= ~res_rptr_q;
      end
      res_cnt_q <= res_cnt_q + 2'(res_push) - 2'(res_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_push) begin
      res_fifo_q[res_wptr_q] <= res_d;
    end
  end

  assign empty = (res_cnt_q == 2'd0);
  assign out_o = res_fifo_q[res_rptr_q];

  `BB3_ASSERT_IMPL(a_pop_when_free, cmd_pop, (state_q == BK_IDLE) || (state_q == BK_PUSH))
  `BB3_ASSERT_NEXT(a_pop_then_rows, cmd_pop, state_q == BK_ROWS)
  `BB3_ASSERT_IMPL(a_count_range, state_q == BK_MUL,
                   (cmd_q.count != '0) && (int'(cmd_q.count) <= int'(MaxCount)))
  `BB3_ASSERT_IMPL(a_quotient_fits, state_q == BK_PUSH,
                   (prod_q[0][ProdW-1:RecipShift+ChanW] == '0) && (prod_q[1][ProdW-1:RecipShift+ChanW] == '0) && (prod_q[2][ProdW-1:RecipShift+ChanW] == '0))

endmodule

[test/box_blur_checker.sv]
module box_blur_checker import bb3_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [CfgW-1:0] cfg_wdata_i,
  input  logic            push,
  input  logic            full,
  input  pixel_in_t       in_i,
  input  logic            pop,
  input  logic            empty,
  input  pixel_out_t      out_o,
  output int unsigned     mismatch_cnt_o,
  output int unsigned     pending_cnt_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MaxPrinted = 40;

  // rows r+1 and r+2 of the frame, indexed by column
  pix_t            line_below     [MaxFrame];
  pix_t            line_two_below [MaxFrame];
  // cells at columns c+1 and c+2 of rows r, r+1, r+2
  pix_t            right1, right2;
  pix_t            below1, below2;
  pix_t            two_below1, two_below2;
  int unsigned     row_pos;
  int unsigned     col_pos;
  logic [CfgW-1:0] frame_reg;
  pixel_out_t      blur_q [$];
  int unsigned     errors;

  function automatic int unsigned active_size();
    int unsigned n;
    n = int'(frame_reg);
    if (n == 0) begin
      n = 1;
    end else if (n > MaxFrame) begin
      n = MaxFrame;
    end
    return n;
  endfunction

  task automatic restart_frame();
    int unsigned n;
    n = active_size();
    row_pos    = n - 1;
    col_pos    = n - 1;
    right1     = '0;
    right2     = '0;
    below1     = '0;
    below2     = '0;
    two_below1 = '0;
    two_below2 = '0;
  endtask

  task automatic report_mismatch(input string msg);
    if (errors < MaxPrinted) begin
      $display("%0t ns: mismatch, %s", $time, msg);
    end
    errors++;
  endtask

  // window mean for the pixel just accepted, then advance the line stores
  task automatic predict_blur(input pixel_in_t px);
    int unsigned n, r, c, cols, cnt;
    int unsigned s;
    logic [ChanW-1:0] mean [NumChan];
    pix_t        cur, here1, here2;
    pixel_out_t  res;
    n = active_size();
    r = (row_pos >= n) ? n - 1 : row_pos;
    c = (col_pos >= n) ? n - 1 : col_pos;
    cur   = px;
    here1 = line_below[c];
    here2 = line_two_below[c];
    cols = 0;
    if (c + 1 < n) cols = 1;
    if (c + 2 < n) cols = 2;
    cnt = 1 + cols;
    if (r + 1 < n) cnt += 1 + cols;
    if (r + 2 < n) cnt += 1 + cols;
    for (int k = 0; k < NumChan; k++) begin
      s = cur[k];
      if (cols >= 1) s += right1[k];
      if (cols >= 2) s += right2[k];
      if (r + 1 < n) begin
        s += here1[k];
        if (cols >= 1) s += below1[k];
        if (cols >= 2) s += below2[k];
      end
      if (r + 2 < n) begin
        s += here2[k];
        if (cols >= 1) s += two_below1[k];
        if (cols >= 2) s += two_below2[k];
      end
      mean[k] = ChanW'(s / cnt);
    end
    res.out_red    = mean[2];
    res.out_green  = mean[1];
    res.out_blue   = mean[0];
    res.frame_done = (r == 0 && c == 0);
    blur_q.push_back(res);

    line_two_below[c] = here1;
    line_below[c]     = cur;
    right2     = right1;
    right1     = cur;
    below2     = below1;
    below1     = here1;
    two_below2 = two_below1;
    two_below1 = here2;
    if (c == 0) begin
      col_pos = n - 1;
      row_pos = (r == 0) ? n - 1 : r - 1;
    end else begin
      col_pos = c - 1;
      row_pos = r;
    end
  endtask

  task automatic check_result(input pixel_out_t got);
    pixel_out_t want;
    if (blur_q.size() == 0) begin
      report_mismatch($sformatf("result %h with nothing expected", got));
    end else begin
      want = blur_q.pop_front();
      if (got.out_red !== want.out_red) begin
        report_mismatch($sformatf("red got %h want %h", got.out_red, want.out_red));
      end
      if (got.out_green !== want.out_green) begin
        report_mismatch($sformatf("green got %h want %h", got.out_green, want.out_green));
      end
      if (got.out_blue !== want.out_blue) begin
        report_mismatch($sformatf("blue got %h want %h", got.out_blue, want.out_blue));
      end
      if (got.frame_done !== want.frame_done) begin
        report_mismatch($sformatf("frame_done got %b want %b",
                                  got.frame_done, want.frame_done));
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_reg = CfgW'(FrameSizeReset);
      restart_frame();
      blur_q.delete();
      errors = 0;
      mismatch_cnt_o <= 0;
      pending_cnt_o  <= 0;
    end else begin
      if (cfg_we_i) begin
        frame_reg = cfg_wdata_i;
        restart_frame();
      end
      if (pop && !empty) check_result(out_o);
      if (push && !full) predict_blur(in_i);
      mismatch_cnt_o <= errors;
      pending_cnt_o  <= blur_q.size();
    end
  end

endmodule

[test/tb.sv]
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import bb3_pkg::*;

  localparam int unsigned StallLimit = 5000;
  localparam int unsigned NumPhases  = 13;

  logic            clk_i       = 1'b0;
  logic            rst_ni      = 1'b0;
  logic            cfg_we_i    = 1'b0;
  logic [CfgW-1:0] cfg_wdata_i = '0;
  logic            push        = 1'b0;
  pixel_in_t       in_i        = '0;
  logic            pop         = 1'b0;
  logic            full;
  logic            empty;
  pixel_out_t      out_o;
  int unsigned     mismatch_cnt;
  int unsigned     pending_cnt;
  int unsigned     gap_pct     = 0;
  int unsigned     stall_pct   = 0;
  int unsigned     idle_cycles = 0;
  int unsigned     phase_size  [NumPhases];
  int unsigned     phase_items [NumPhases];

  box_blur_3x3_truncated_top u_dut (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_wdata_i,
    .push,
    .in_i,
    .full,
    .empty,
    .out_o,
    .pop
  );

  box_blur_checker u_checker (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_wdata_i,
    .push,
    .full,
    .in_i,
    .pop,
    .empty,
    .out_o,
    .mismatch_cnt_o (mismatch_cnt),
    .pending_cnt_o  (pending_cnt)
  );

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    pop <= rst_ni && ($urandom_range(99) >= stall_pct);
  end

  // no transaction on either side for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (push && !full) || (pop && !empty)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= StallLimit) begin
      $display("FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic pixel_in_t random_pixel();
    pix_t px;
    for (int k = 0; k < NumChan; k++) begin
      case ($urandom_range(7))
        0:       px[k] = '0;
        1:       px[k] = '1;
        default: px[k] = ChanW'($urandom_range(65535));
      endcase
    end
    return pixel_in_t'(px);
  endfunction

  function automatic pixel_in_t directed_pixel(input int unsigned i);
    pixel_in_t px;
    case (i % 3)
      0:       px = '1;
      1:       px = '0;
      default: px = '{in_red: 16'hffff, in_green: 16'h0000, in_blue: 16'h8001};
    endcase
    return px;
  endfunction

  task automatic send_pixel(input pixel_in_t px);
    push <= 1'b1;
    in_i <= px;
    do @(posedge clk_i); while (full);
    if ($urandom_range(99) < gap_pct) begin
      push <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < gap_pct);
    end
  endtask

  task automatic wait_drained();
    push <= 1'b0;
    @(posedge clk_i);
    while (pending_cnt != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_frame_size(input logic [CfgW-1:0] v);
    wait_drained();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    int unsigned p, i, n;
    phase_size  = '{5, 4, 1, 2, 3, 6, 16, 37, 1024, 2047, 0, 64, 11};
    phase_items = '{120, 60, 20, 30, 40, 80, 200, 150, 480, 250, 20, 200, 150};
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset frame size, then the smallest frames through a wrap
    for (i = 0; i < 3; i++) send_pixel(directed_pixel(i));
    for (p = 0; p < 4; p++) begin
      write_frame_size(CfgW'(p));
      n = (p == 0) ? 1 : p;
      for (i = 0; i < n * n + 1; i++) send_pixel(directed_pixel(i));
    end

    for (p = 0; p < NumPhases; p++) begin
      write_frame_size(CfgW'(phase_size[p]));
      case (p % 4)
        0: begin
          gap_pct = 0;
          stall_pct <= 0;
        end
        1: begin
          gap_pct = 54;
          stall_pct <= 0;
        end
        2: begin
          gap_pct = 0;
          stall_pct <= 54;
        end
        default: begin
          gap_pct = 32;
          stall_pct <= 32;
        end
      endcase
      for (i = 0; i < phase_items[p]; i++) begin
        send_pixel(random_pixel());
        if ($urandom_range(63) == 0) wait_drained();
      end
    end

    wait_drained();
    repeat (20) @(posedge clk_i);
    if (mismatch_cnt == 0 && pending_cnt == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
